@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Each one checks on the rising clock edge and
// stays quiet while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define NOEV_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define NOEV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the following cycle.
`define NOEV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/noev_pkg.sv @@
`default_nettype none

package noev_pkg;

    // Port widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;
    localparam int IDX_W     = 2;
    localparam int CFG_W     = 12;

    // Field and datapath widths.
    localparam int PNT_W   = 16;   // input coordinate
    localparam int RAD_W   = 12;   // radius and box limit
    localparam int SPD_W   = 10;   // escape speed
    localparam int COORD_W = 13;   // a coordinate inside the box
    localparam int MAG_W   = 12;   // its magnitude
    localparam int SQ_W    = 24;   // square of a magnitude
    localparam int DIST_W  = 25;   // squared distance
    localparam int THR_W   = 13;   // radius plus clearance
    localparam int TSQ_W   = 26;   // square of that
    localparam int ROOT_W  = 13;   // integer square root of a distance
    localparam int NUM_W   = 22;   // speed times magnitude
    localparam int QUO_W   = 10;   // quotient, never above the speed
    localparam int VEL_W   = 11;   // signed velocity

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0] DIST_ONES    = '1;
    localparam logic [THR_W-1:0]  CLEARANCE_MM = 13'd20;
    localparam logic [SPD_W-1:0]  SPEED_MAX    = 10'd1000;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOX    = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPEED  = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Summary of one finished scan, handed from the front to the back.
    typedef struct packed {
        logic              any;
        logic [DIST_W-1:0] d2;
        t_coord            x;
        t_coord            y;
    } t_scan;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    too_close;
        logic                    no_point;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/nearest_obstacle_escape_vector.sv @@
`default_nettype none

// Nearest-obstacle escape vector. Obstacle points arrive as words on the slave stream, x and
// y in signed millimetres with tlast on the final point of a scan; points whose |x| or |y|
// exceeds the box limit are skipped, and among the rest the nearest (by squared distance,
// earlier point on a tie) is kept. For every scan one word leaves on the master stream: zero
// velocity with no_point_seen set when nothing fell inside the box, zero velocity when the
// nearest point lies beyond robot radius plus 20 mm, and otherwise a velocity of magnitude
// escape_speed (saturated at 1000) pointing away from that point (zero for a point at the
// origin), each component truncated toward zero, with too_close set. The front accepts one
// point per clock unless held back by a full queue: it registers the box test and squares,
// then compares and updates the best point from those registers. Finished scans wait in a
// queue of QUEUE_DEPTH entries for the back, which works on one scan at a time: it takes it
// from the queue, tests the distance, for a close point runs a bit-serial square root and
// division, and hands the word to the output register once tready has taken any earlier
// word. Scans that come faster than the back finishes them are absorbed only up to the queue
// depth, and when the queue is full the front holds back the last point of the next scan.
// Configuration writes take effect at once and should be made while no scan is in flight.

module nearest_obstacle_escape_vector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Point stream in.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [noev_pkg::S_TDATA_W-1:0] i_s_tdata,   // point_x, point_y
    input  wire logic                           i_s_tlast,   // scan_last
    // Velocity stream out.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [noev_pkg::M_TDATA_W-1:0]      o_m_tdata,   // vel_x, vel_y, zero fill
    output logic [noev_pkg::M_TUSER_W-1:0]      o_m_tuser,   // too_close, no_point_seen
    // Register writes.
    input  wire logic                           i_cfg_we,
    input  wire logic [noev_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [noev_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import noev_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [RAD_W-1:0] r_box;
    logic [SPD_W-1:0] r_speed;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_scan   w_scan_in;
    t_scan   w_scan_out;
    t_result w_result;

    // Configuration registers; an unused index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 12'd500;
            r_box    <= 12'd2000;
            r_speed  <= 10'd80;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS: r_radius <= i_cfg_wdata[RAD_W-1:0];
                REG_BOX:    r_box    <= i_cfg_wdata[RAD_W-1:0];
                REG_SPEED:  r_speed  <= i_cfg_wdata[SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front finds the nearest point of each scan.
    noev_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_x         (i_s_tdata[PNT_W-1:0]),
        .i_y         (i_s_tdata[2*PNT_W-1:PNT_W]),
        .i_last      (i_s_tlast),
        .i_box_limit (r_box),
        .o_push      (w_push),
        .o_scan      (w_scan_in),
        .i_full      (w_full)
    );

    // Queue of finished scans between front and back.
    noev_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_scan_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_scan_out),
        .o_empty (w_empty)
    );

    // The back turns each scan into a velocity word.
    noev_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_scan   (w_scan_out),
        .i_radius (r_radius),
        .i_speed  (r_speed),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = {{(M_TDATA_W-2*VEL_W){1'b0}}, w_result.vel_y, w_result.vel_x};
    assign o_m_tuser = {w_result.no_point, w_result.too_close};

endmodule

`default_nettype wire

@@ hw/rtl/noev_front.sv @@
`default_nettype none

module noev_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [15:0]         i_x,
    input  wire logic signed [15:0]         i_y,
    input  wire logic                       i_last,
    input  wire logic [noev_pkg::RAD_W-1:0] i_box_limit,
    output logic                            o_push,
    output noev_pkg::t_scan                 o_scan,
    input  wire logic                       i_full
);
    import noev_pkg::*;

    logic [PNT_W-1:0]  w_magx;
    logic [PNT_W-1:0]  w_magy;
    logic              w_inbox;
    logic [SQ_W-1:0]   w_sqx;
    logic [SQ_W-1:0]   w_sqy;
    logic              w_adv;
    logic [DIST_W-1:0] w_d2;
    logic              w_take;

    logic              r_s1_v;
    logic              r_s1_last;
    logic              r_s1_in;
    t_coord            r_s1_x;
    t_coord            r_s1_y;
    logic [SQ_W-1:0]   r_s1_sqx;
    logic [SQ_W-1:0]   r_s1_sqy;

    logic [DIST_W-1:0] r_best_d2;
    t_coord            r_best_x;
    t_coord            r_best_y;
    logic              r_any;
    logic [DIST_W-1:0] n_best_d2;
    t_coord            n_best_x;
    t_coord            n_best_y;
    logic              n_any;

    // Classify: box test and squares, registered.
    assign w_magx  = i_x[PNT_W-1] ? PNT_W'(-i_x) : PNT_W'(i_x);
    assign w_magy  = i_y[PNT_W-1] ? PNT_W'(-i_y) : PNT_W'(i_y);
    assign w_inbox = (w_magx <= {{(PNT_W-RAD_W){1'b0}}, i_box_limit})
                  && (w_magy <= {{(PNT_W-RAD_W){1'b0}}, i_box_limit});
    assign w_sqx   = {{(SQ_W-MAG_W){1'b0}}, w_magx[MAG_W-1:0]}
                   * {{(SQ_W-MAG_W){1'b0}}, w_magx[MAG_W-1:0]};
    assign w_sqy   = {{(SQ_W-MAG_W){1'b0}}, w_magy[MAG_W-1:0]}
                   * {{(SQ_W-MAG_W){1'b0}}, w_magy[MAG_W-1:0]};

    // A last point can only leave when the queue has room for its scan.
    assign w_adv   = r_s1_v && (!r_s1_last || !i_full);
    assign o_ready = !r_s1_v || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_ready) begin
            r_s1_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_last <= i_last;
            r_s1_in   <= w_inbox;
            r_s1_x    <= i_x[COORD_W-1:0];
            r_s1_y    <= i_y[COORD_W-1:0];
            r_s1_sqx  <= w_sqx;
            r_s1_sqy  <= w_sqy;
        end
    end

    // Keep the nearest point; an equal distance leaves the earlier one.
    assign w_d2   = DIST_W'(r_s1_sqx) + DIST_W'(r_s1_sqy);
    assign w_take = r_s1_in && (w_d2 < r_best_d2);

    always_comb begin
        n_best_d2 = w_take ? w_d2 : r_best_d2;
        n_best_x  = w_take ? r_s1_x : r_best_x;
        n_best_y  = w_take ? r_s1_y : r_best_y;
        n_any     = r_any | r_s1_in;
    end

    assign o_push = w_adv && r_s1_last;
    assign o_scan = '{any: n_any, d2: n_best_d2, x: n_best_x, y: n_best_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_d2 <= DIST_ONES;
            r_best_x  <= '0;
            r_best_y  <= '0;
            r_any     <= 1'b0;
        end else if (w_adv) begin
            if (r_s1_last) begin
                r_best_d2 <= DIST_ONES;
                r_best_x  <= '0;
                r_best_y  <= '0;
                r_any     <= 1'b0;
            end else begin
                r_best_d2 <= n_best_d2;
                r_best_x  <= n_best_x;
                r_best_y  <= n_best_y;
                r_any     <= n_any;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/noev_queue.sv @@
`default_nettype none

`include "assert_macros.svh"

module noev_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire noev_pkg::t_scan i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output noev_pkg::t_scan      o_data,
    output logic                 o_empty
);
    import noev_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_scan            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `NOEV_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH), "queue overfilled")
    `NOEV_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push when full")
    `NOEV_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop when empty")

endmodule

`default_nettype wire

@@ hw/rtl/noev_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module noev_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    output logic                            o_pop,
    input  wire noev_pkg::t_scan            i_scan,
    input  wire logic [noev_pkg::RAD_W-1:0] i_radius,
    input  wire logic [noev_pkg::SPD_W-1:0] i_speed,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output noev_pkg::t_result               o_result
);
    import noev_pkg::*;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] ST_CHK  = 3'd1;
    localparam logic [STATE_W-1:0] ST_SQRT = 3'd2;
    localparam logic [STATE_W-1:0] ST_DIV  = 3'd3;
    localparam logic [STATE_W-1:0] ST_FIN  = 3'd4;

    logic [STATE_W-1:0]  r_state;
    t_coord              r_x;
    t_coord              r_y;
    logic [DIST_W-1:0]   r_d2;
    logic                r_any;
    logic [TSQ_W-1:0]    r_tsq;
    logic [SPD_W-1:0]    r_spd;
    logic [2*ROOT_W-1:0] r_rad;
    logic [ROOT_W:0]     r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [STEP_W-1:0]   r_cnt;
    logic [NUM_W-1:0]    r_nx;
    logic [NUM_W-1:0]    r_ny;
    logic [ROOT_W-1:0]   r_drx;
    logic [ROOT_W-1:0]   r_dry;
    t_result             r_res;
    logic                r_ov;
    t_result             r_out;

    logic [THR_W-1:0]    w_t;
    logic [COORD_W-1:0]  w_mx;
    logic [COORD_W-1:0]  w_my;
    logic                w_px;
    logic                w_py;
    logic                w_close;
    logic [ROOT_W+2:0]   w_sh;
    logic [ROOT_W+2:0]   w_trial;
    logic                w_sge;
    logic [ROOT_W:0]     w_rem_n;
    logic [ROOT_W-1:0]   w_root_n;
    logic [ROOT_W:0]     w_shx;
    logic [ROOT_W:0]     w_shy;
    logic                w_gex;
    logic                w_gey;
    logic [NUM_W-1:0]    w_qx;
    logic [NUM_W-1:0]    w_qy;
    logic [VEL_W-1:0]    w_ax;
    logic [VEL_W-1:0]    w_ay;
    logic                w_load_out;

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    assign w_t  = THR_W'(i_radius) + CLEARANCE_MM;
    assign w_mx = r_x[COORD_W-1] ? COORD_W'(-r_x) : COORD_W'(r_x);
    assign w_my = r_y[COORD_W-1] ? COORD_W'(-r_y) : COORD_W'(r_y);
    // A positive coordinate pushes the robot the other way.
    assign w_px = !r_x[COORD_W-1] && (r_x != '0);
    assign w_py = !r_y[COORD_W-1] && (r_y != '0);
    assign w_close = r_any && ({1'b0, r_d2} <= r_tsq);

    // Square root, one result bit a step.
    assign w_sh     = {r_rem, r_rad[2*ROOT_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_sge    = (w_sh >= w_trial);
    assign w_rem_n  = w_sge ? (ROOT_W+1)'(w_sh - w_trial) : w_sh[ROOT_W:0];
    assign w_root_n = {r_root[ROOT_W-2:0], w_sge};

    // Two restoring dividers that share the root as divisor.
    assign w_shx = {r_drx, r_nx[NUM_W-1]};
    assign w_shy = {r_dry, r_ny[NUM_W-1]};
    assign w_gex = (w_shx >= {1'b0, r_root});
    assign w_gey = (w_shy >= {1'b0, r_root});
    assign w_qx  = {r_nx[NUM_W-2:0], w_gex};
    assign w_qy  = {r_ny[NUM_W-2:0], w_gey};
    assign w_ax  = {{(VEL_W-QUO_W){1'b0}}, w_qx[QUO_W-1:0]};
    assign w_ay  = {{(VEL_W-QUO_W){1'b0}}, w_qy[QUO_W-1:0]};

    assign w_load_out = (r_state == ST_FIN) && (!r_ov || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_state <= w_close ? ST_SQRT : ST_FIN;
                end
                ST_SQRT: begin
                    if (r_cnt == '0) begin
                        r_state <= (w_root_n == '0) ? ST_FIN : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x   <= i_scan.x;
                r_y   <= i_scan.y;
                r_d2  <= i_scan.d2;
                r_any <= i_scan.any;
                r_tsq <= {{(TSQ_W-THR_W){1'b0}}, w_t} * {{(TSQ_W-THR_W){1'b0}}, w_t};
                r_spd <= (i_speed > SPEED_MAX) ? SPEED_MAX : i_speed;
            end
            ST_CHK: begin
                r_nx   <= {{(NUM_W-MAG_W){1'b0}}, w_mx[MAG_W-1:0]}
                        * {{(NUM_W-SPD_W){1'b0}}, r_spd};
                r_ny   <= {{(NUM_W-MAG_W){1'b0}}, w_my[MAG_W-1:0]}
                        * {{(NUM_W-SPD_W){1'b0}}, r_spd};
                r_rad  <= {{(2*ROOT_W-DIST_W){1'b0}}, r_d2};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= STEP_W'(SQRT_STEPS - 1);
                r_res  <= '{vel_x: '0, vel_y: '0, too_close: w_close, no_point: !r_any};
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[2*ROOT_W-3:0], 2'b00};
                r_rem  <= w_rem_n;
                r_root <= w_root_n;
                r_drx  <= '0;
                r_dry  <= '0;
                r_cnt  <= (r_cnt == '0) ? STEP_W'(DIV_STEPS - 1) : r_cnt - 1'b1;
            end
            ST_DIV: begin
                r_drx <= w_gex ? ROOT_W'(w_shx - {1'b0, r_root}) : w_shx[ROOT_W-1:0];
                r_dry <= w_gey ? ROOT_W'(w_shy - {1'b0, r_root}) : w_shy[ROOT_W-1:0];
                r_nx  <= w_qx;
                r_ny  <= w_qy;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_res.vel_x <= w_px ? -w_ax : w_ax;
                    r_res.vel_y <= w_py ? -w_ay : w_ay;
                end
            end
            ST_FIN: begin
                if (w_load_out) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

    `NOEV_ASSERT_IMPLY(a_far_is_still, i_clk, i_rst_n, r_ov && !r_out.too_close,
        r_out.vel_x == '0 && r_out.vel_y == '0, "velocity without a near point")
    `NOEV_ASSERT_IMPLY(a_empty_not_close, i_clk, i_rst_n, r_ov && r_out.no_point,
        !r_out.too_close, "empty scan flagged as too close")
    `NOEV_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_state == ST_CHK, "pop lost")

endmodule

`default_nettype wire
